// ===== design/pcps_pkg.sv =====
// ----------------------------------------------------------------------------
// pcps_pkg - shared types and constants of the power cycle ping supervisor
// Event codes, power modes, reachability codes, register map and the
// structures that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package pcps_pkg;

  // Event codes carried by the action field
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ON      = 3'd1,
    ACT_OFF     = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_CHECK   = 3'd4,
    ACT_RESULT  = 3'd5
  } action_t;

  // Power modes
  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  // Reachability status codes
  typedef enum logic [2:0] {
    ST_UNKNOWN        = 3'd0,
    ST_BOOTING        = 3'd1,
    ST_CHECKING       = 3'd2,
    ST_RESPONDING     = 3'd3,
    ST_NOT_RESPONDING = 3'd4
  } status_t;

  // Register indexes (byte address is 4 times the index)
  typedef enum logic [2:0] {
    REG_RESTART_DELAY = 3'd0,
    REG_CONTINUOUS    = 3'd1,
    REG_INTERVAL      = 3'd2,
    REG_GRACE         = 3'd3,
    REG_THRESHOLD     = 3'd4
  } reg_idx_t;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned MS_PER_S  = 1000;

  localparam int unsigned DELAY_W    = 4;
  localparam int unsigned INTERVAL_W = 9;
  localparam int unsigned GRACE_W    = 17;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned RESTART_W  = 14;
  localparam int unsigned SINCE_W    = 19;
  localparam int unsigned FAIL_W     = 8;

  // Reset values of the registers
  localparam logic [DELAY_W-1:0]    RST_DELAY     = 4'd3;
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL  = 9'd10;
  localparam logic [GRACE_W-1:0]    RST_GRACE     = 17'd90000;
  localparam logic [THRESH_W-1:0]   RST_THRESHOLD = 8'd3;

  typedef struct packed {
    logic [DELAY_W-1:0]    restart_delay_s;
    logic                  continuous_check;
    logic [INTERVAL_W-1:0] check_interval_s;
    logic [GRACE_W-1:0]    grace_window_ms;
    logic [THRESH_W-1:0]   fail_threshold;
  } cfg_t;

  typedef struct packed {
    mode_t               power_mode;
    logic                relay_off;
    status_t             reach_status;
    logic                check_request;
    logic [FAIL_W-1:0]   fail_count;
    logic                grace_active;
    logic                command_taken;
  } res_t;

endpackage

// ===== design/pcps_regs.sv =====
// ----------------------------------------------------------------------------
// pcps_regs - configuration register file
// APB-style slave holding the five supervisor settings; always ready.
// ----------------------------------------------------------------------------
module pcps_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcps_pkg::PADDR_W-1:0]  paddr,
  input  logic [pcps_pkg::PDATA_W-1:0]  pwdata,
  output logic [pcps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output pcps_pkg::cfg_t                cfg
);

  logic     wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.restart_delay_s  <= pcps_pkg::RST_DELAY;
      cfg.continuous_check <= 1'b0;
      cfg.check_interval_s <= pcps_pkg::RST_INTERVAL;
      cfg.grace_window_ms  <= pcps_pkg::RST_GRACE;
      cfg.fail_threshold   <= pcps_pkg::RST_THRESHOLD;
    end else if (wr_en) begin
      case (idx)
        pcps_pkg::REG_RESTART_DELAY:
          cfg.restart_delay_s <= pwdata[pcps_pkg::DELAY_W-1:0];
        pcps_pkg::REG_CONTINUOUS:
          cfg.continuous_check <= pwdata[0];
        pcps_pkg::REG_INTERVAL:
          cfg.check_interval_s <= pwdata[pcps_pkg::INTERVAL_W-1:0];
        pcps_pkg::REG_GRACE:
          cfg.grace_window_ms <= pwdata[pcps_pkg::GRACE_W-1:0];
        pcps_pkg::REG_THRESHOLD:
          cfg.fail_threshold <= pwdata[pcps_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (idx)
      pcps_pkg::REG_RESTART_DELAY:
        prdata = pcps_pkg::PDATA_W'(cfg.restart_delay_s);
      pcps_pkg::REG_CONTINUOUS:
        prdata = pcps_pkg::PDATA_W'(cfg.continuous_check);
      pcps_pkg::REG_INTERVAL:
        prdata = pcps_pkg::PDATA_W'(cfg.check_interval_s);
      pcps_pkg::REG_GRACE:
        prdata = pcps_pkg::PDATA_W'(cfg.grace_window_ms);
      pcps_pkg::REG_THRESHOLD:
        prdata = pcps_pkg::PDATA_W'(cfg.fail_threshold);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== design/pcps_core.sv =====
// ----------------------------------------------------------------------------
// pcps_core - supervisor state and event handling
// Holds the power, grace, check and failure state, and works out in one pass
// the next state and the result for the event in the input register.
// ----------------------------------------------------------------------------
module pcps_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic [2:0]           action,
  input  logic                 reply_ok,
  input  pcps_pkg::cfg_t       cfg,
  output pcps_pkg::res_t       res
);

  pcps_pkg::mode_t   mode_reg, mode_next;
  pcps_pkg::status_t status_reg, status_next;
  pcps_pkg::status_t status_before_check, status_before_check_next;
  logic [pcps_pkg::RESTART_W-1:0] restart_elapsed, restart_elapsed_next;
  logic [pcps_pkg::GRACE_W-1:0]   grace_elapsed, grace_elapsed_next;
  logic [pcps_pkg::SINCE_W-1:0]   since_check_ms, since_check_ms_next;
  logic [pcps_pkg::FAIL_W-1:0]    fail_counter, fail_counter_next;
  logic grace_flag, grace_flag_next;
  logic has_checked, has_checked_next;
  logic check_wanted, check_wanted_next;
  logic check_pending, check_pending_next;
  logic launched_in_grace, launched_in_grace_next;

  logic [pcps_pkg::RESTART_W-1:0] restart_limit;
  logic [pcps_pkg::SINCE_W-1:0]   interval_limit;

  // Seconds to milliseconds, constant multiply
  assign restart_limit  = pcps_pkg::RESTART_W'(cfg.restart_delay_s)
                          * pcps_pkg::RESTART_W'(pcps_pkg::MS_PER_S);
  assign interval_limit = pcps_pkg::SINCE_W'(cfg.check_interval_s)
                          * pcps_pkg::SINCE_W'(pcps_pkg::MS_PER_S);

  // Next state and result for one event
  always_comb begin
    logic launched;
    logic taken;
    logic in_window;
    logic periodic;

    mode_next                = mode_reg;
    status_next              = status_reg;
    status_before_check_next = status_before_check;
    restart_elapsed_next     = restart_elapsed;
    grace_elapsed_next       = grace_elapsed;
    since_check_ms_next      = since_check_ms;
    fail_counter_next        = fail_counter;
    grace_flag_next          = grace_flag;
    has_checked_next         = has_checked;
    check_wanted_next        = check_wanted;
    check_pending_next       = check_pending;
    launched_in_grace_next   = launched_in_grace;
    launched                 = 1'b0;
    taken                    = 1'b1;
    in_window                = 1'b0;
    periodic                 = 1'b0;

    case (pcps_pkg::action_t'(action))
      pcps_pkg::ACT_TICK: begin
        // advance the millisecond counters
        if (has_checked && since_check_ms != '1) begin
          since_check_ms_next = since_check_ms + pcps_pkg::SINCE_W'(1);
        end
        if (mode_reg == pcps_pkg::MODE_RESTART) begin
          if (restart_elapsed != '1) begin
            restart_elapsed_next = restart_elapsed + pcps_pkg::RESTART_W'(1);
          end
          if (restart_elapsed_next >= restart_limit) begin
            mode_next          = pcps_pkg::MODE_ON;
            grace_elapsed_next = '0;
            grace_flag_next    = 1'b1;
            fail_counter_next  = '0;
            status_next        = pcps_pkg::ST_BOOTING;
            check_wanted_next  = cfg.continuous_check;
          end
        end else if (mode_reg == pcps_pkg::MODE_ON && grace_flag &&
                     grace_elapsed != '1) begin
          grace_elapsed_next = grace_elapsed + pcps_pkg::GRACE_W'(1);
        end
        // monitor pass while powered on
        if (mode_next == pcps_pkg::MODE_ON) begin
          if (grace_flag_next) begin
            if (grace_elapsed_next < cfg.grace_window_ms) begin
              in_window = 1'b1;
              if (!check_pending && status_next != pcps_pkg::ST_RESPONDING) begin
                status_next = pcps_pkg::ST_BOOTING;
              end
            end else begin
              grace_flag_next = 1'b0;
            end
          end
          periodic = cfg.continuous_check &&
                     (!has_checked || since_check_ms_next >= interval_limit);
          if (!check_pending && (check_wanted_next || periodic)) begin
            check_wanted_next        = 1'b0;
            has_checked_next         = 1'b1;
            since_check_ms_next      = '0;
            status_before_check_next = status_next;
            status_next              = pcps_pkg::ST_CHECKING;
            check_pending_next       = 1'b1;
            launched_in_grace_next   = in_window;
            launched                 = 1'b1;
          end
        end
      end
      pcps_pkg::ACT_ON: begin
        check_pending_next = 1'b0;
        mode_next          = pcps_pkg::MODE_ON;
        grace_elapsed_next = '0;
        grace_flag_next    = 1'b1;
        fail_counter_next  = '0;
        status_next        = pcps_pkg::ST_BOOTING;
        check_wanted_next  = cfg.continuous_check;
      end
      pcps_pkg::ACT_OFF: begin
        check_pending_next = 1'b0;
        mode_next          = pcps_pkg::MODE_OFF;
        grace_flag_next    = 1'b0;
        check_wanted_next  = 1'b0;
        fail_counter_next  = '0;
        status_next        = pcps_pkg::ST_UNKNOWN;
      end
      pcps_pkg::ACT_RESTART: begin
        if (mode_reg == pcps_pkg::MODE_RESTART) begin
          taken = 1'b0;
        end else begin
          check_pending_next   = 1'b0;
          mode_next            = pcps_pkg::MODE_RESTART;
          restart_elapsed_next = '0;
          grace_flag_next      = 1'b0;
          check_wanted_next    = 1'b0;
          fail_counter_next    = '0;
          status_next          = pcps_pkg::ST_BOOTING;
        end
      end
      pcps_pkg::ACT_CHECK: begin
        if (mode_reg != pcps_pkg::MODE_ON) begin
          taken = 1'b0;
        end else begin
          check_wanted_next = 1'b1;
        end
      end
      pcps_pkg::ACT_RESULT: begin
        // drop a result that has no check waiting for it
        if (check_pending) begin
          check_pending_next = 1'b0;
          if (reply_ok) begin
            fail_counter_next = '0;
            grace_flag_next   = 1'b0;
            status_next       = pcps_pkg::ST_RESPONDING;
          end else if (launched_in_grace) begin
            fail_counter_next = '0;
            status_next       = pcps_pkg::ST_BOOTING;
          end else begin
            if (fail_counter != '1) begin
              fail_counter_next = fail_counter + pcps_pkg::FAIL_W'(1);
            end
            if (fail_counter_next >= cfg.fail_threshold) begin
              status_next = pcps_pkg::ST_NOT_RESPONDING;
            end else if (status_before_check == pcps_pkg::ST_RESPONDING) begin
              status_next = pcps_pkg::ST_RESPONDING;
            end else begin
              status_next = pcps_pkg::ST_UNKNOWN;
            end
          end
        end
      end
      default: ;
    endcase

    res.power_mode    = mode_next;
    res.relay_off     = (mode_next != pcps_pkg::MODE_ON);
    res.reach_status  = status_next;
    res.check_request = launched;
    res.fail_count    = fail_counter_next;
    res.grace_active  = grace_flag_next;
    res.command_taken = taken;
  end

  // Hold the state, advance it on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg            <= pcps_pkg::MODE_ON;
      status_reg          <= pcps_pkg::ST_UNKNOWN;
      status_before_check <= pcps_pkg::ST_UNKNOWN;
      restart_elapsed     <= '0;
      grace_elapsed       <= '0;
      since_check_ms      <= '0;
      fail_counter        <= '0;
      grace_flag          <= 1'b0;
      has_checked         <= 1'b0;
      check_wanted        <= 1'b0;
      check_pending       <= 1'b0;
      launched_in_grace   <= 1'b0;
    end else if (step_en) begin
      mode_reg            <= mode_next;
      status_reg          <= status_next;
      status_before_check <= status_before_check_next;
      restart_elapsed     <= restart_elapsed_next;
      grace_elapsed       <= grace_elapsed_next;
      since_check_ms      <= since_check_ms_next;
      fail_counter        <= fail_counter_next;
      grace_flag          <= grace_flag_next;
      has_checked         <= has_checked_next;
      check_wanted        <= check_wanted_next;
      check_pending       <= check_pending_next;
      launched_in_grace   <= launched_in_grace_next;
    end
  end

  // A pending check only lives while powered on
  a_pending_on: assert property (@(posedge clk) disable iff (rst)
    check_pending |-> mode_reg == pcps_pkg::MODE_ON)
    else $error("check pending outside power on");

  // Grace window only open while powered on
  a_grace_on: assert property (@(posedge clk) disable iff (rst)
    grace_flag |-> mode_reg == pcps_pkg::MODE_ON)
    else $error("grace window open outside power on");

  // Checking status goes with a pending check
  a_checking: assert property (@(posedge clk) disable iff (rst)
    status_reg == pcps_pkg::ST_CHECKING |-> check_pending)
    else $error("checking status without pending check");

endmodule

// ===== design/power_cycle_ping_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// power_cycle_ping_supervisor_top - relay power cycle supervisor
// Usage:
//   Input channel (in_valid/in_stall): one event per transaction, carrying
//   action (tick, on, off, restart, check now, ping result) and reply_ok.
//   Output channel (out_valid/out_stall): exactly one result transaction per
//   event, in order: power mode, relay level, reachability status, check
//   launch strobe, failure count, grace flag and command acceptance.
//   An event is taken into the input register, handled by one pass of the
//   state logic and its result is loaded into the output register when that
//   register is free; one event per cycle is sustained while the receiver
//   does not stall. When the receiver stalls, the result holds in the output
//   register; one further event is still taken into the input register, after
//   which in_stall rises until the output register drains. Reset (rst,
//   synchronous) empties both registers, powers the load on with status unknown
//   and loads the register defaults. The user must write settings over the
//   APB-style port only while no event is in flight; the block does not
//   enforce this.
// ----------------------------------------------------------------------------
module power_cycle_ping_supervisor_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcps_pkg::PADDR_W-1:0]  paddr,
  input  logic [pcps_pkg::PDATA_W-1:0]  pwdata,
  output logic [pcps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    action,
  input  logic                          reply_ok,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    power_mode,
  output logic                          relay_off,
  output logic [2:0]                    reach_status,
  output logic                          check_request,
  output logic [7:0]                    fail_count,
  output logic                          grace_active,
  output logic                          command_taken
);

  pcps_pkg::cfg_t cfg;
  pcps_pkg::res_t res_next;
  pcps_pkg::res_t res;

  logic       s1_valid;
  logic [2:0] s1_action;
  logic       s1_reply_ok;
  logic       in_take;
  logic       advance;

  pcps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcps_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .action   (s1_action),
    .reply_ok (s1_reply_ok),
    .cfg      (cfg),
    .res      (res_next)
  );

  // Move the held event on whenever the output register is free
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action   <= action;
      s1_reply_ok <= reply_ok;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign power_mode    = res.power_mode;
  assign relay_off     = res.relay_off;
  assign reach_status  = res.reach_status;
  assign check_request = res.check_request;
  assign fail_count    = res.fail_count;
  assign grace_active  = res.grace_active;
  assign command_taken = res.command_taken;

  // Stall only with an event held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // A processed event always leaves a result behind
  a_result_made: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed event produced no result");

  // A launch strobe always reports the checking status
  a_launch_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_request |-> reach_status == pcps_pkg::ST_CHECKING)
    else $error("check launched without checking status");

endmodule
